// ----- rtl/core/sliding_window_median_defines.svh -----
// Assertion macros for the running median filter.
// Depends on nothing; the including module supplies clk and rst.
`ifndef SLIDING_WINDOW_MEDIAN_DEFINES_SVH
`define SLIDING_WINDOW_MEDIAN_DEFINES_SVH

// Check that cond holds in the same cycle as trig.
`define SWM_ASSERT_SAME(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("median filter check failed");

// Check that cond holds in the cycle after trig.
`define SWM_ASSERT_NEXT(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("median filter check failed");

`endif

// ----- rtl/core/swm_pkg.sv -----
// Shared constants for the running median filter.
// Used by the channel interfaces and the top level; depends on nothing.
package swm_pkg;

  localparam int MAX_WINDOW = 16;
  localparam int SAMPLE_W   = 16;
  localparam int MEDIAN_W   = SAMPLE_W + 1;
  localparam int WIN_W      = $clog2(MAX_WINDOW + 1);
  localparam int PTR_W      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

  localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(3);
  localparam logic [WIN_W-1:0] WIN_MAX   = WIN_W'(MAX_WINDOW);
  localparam logic [WIN_W-1:0] WIN_MIN   = WIN_W'(1);

endpackage

// ----- rtl/core/swm_sample_if.sv -----
// Input channel of the median filter: valid/ready plus one sample.
// Depends on swm_pkg.
interface swm_sample_if;
  import swm_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// ----- rtl/core/swm_median_if.sv -----
// Output channel of the median filter: valid/ready plus the doubled median.
// Depends on swm_pkg.
interface swm_median_if;
  import swm_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [MEDIAN_W-1:0] median_doubled;

  modport source (output valid, output median_doubled, input ready);
  modport sink   (input valid, input median_doubled, output ready);
endinterface

// ----- rtl/core/sliding_window_median.sv -----
// Top level of the running median filter: input register, sorted cell row,
// history slots and result register. Depends on swm_pkg, the two channel
// interfaces and sliding_window_median_defines.svh.
`include "sliding_window_median_defines.svh"

// Running median filter. Each sample transaction enters an input register; when
// it advances, a row of MAX_WINDOW sorted cells drops the oldest sample (once
// the window is full) and inserts the new one by parallel compares, and the
// doubled median (or, for an even window, the sum of the two middle values)
// lands in the result register. One sample is taken every cycle unless the
// input stalls; each goes from the input register, through the compare row
// of the sorted cells, into the result register. The input
// stalls only while a result is waiting and the output is not ready. The
// first window_size - 1 samples after reset or after a write of window_size
// give no result. Writes of window_size clamp 0 to 1 and values above
// MAX_WINDOW to MAX_WINDOW, and restart the window empty.
module sliding_window_median (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [swm_pkg::WIN_W-1:0] cfg_wdata,
  swm_sample_if.sink                samples,
  swm_median_if.source              medians
);
  import swm_pkg::*;

  // Window state
  logic [WIN_W-1:0]           window_size;
  logic [WIN_W-1:0]           fill_count;
  logic [PTR_W-1:0]           oldest_pointer;
  logic signed [SAMPLE_W-1:0] history [MAX_WINDOW];
  logic signed [SAMPLE_W-1:0] sorted_window [MAX_WINDOW];
  logic signed [SAMPLE_W-1:0] sorted_next [MAX_WINDOW];

  // Pipeline registers
  logic                       s1_valid;
  logic signed [SAMPLE_W-1:0] s1_sample;
  logic                       res_valid;
  logic signed [MEDIAN_W-1:0] res_median;

  // Update logic
  logic                       full;
  logic                       gives_result;
  logic                       s1_adv;
  logic [WIN_W-1:0]           ins_count;
  logic [PTR_W-1:0]           hist_idx;
  logic [WIN_W-1:0]           ptr_inc;
  logic [PTR_W-1:0]           oldest_pointer_next;
  logic signed [SAMPLE_W-1:0] old_sample;
  logic signed [SAMPLE_W-1:0] removed [MAX_WINDOW];
  logic [MAX_WINDOW-1:0]      below;
  logic [WIN_W-1:0]           med_hi;
  logic [PTR_W-1:0]           idx_hi;
  logic [PTR_W-1:0]           idx_lo;
  logic signed [MEDIAN_W-1:0] median_next;
  logic [WIN_W-1:0]           cfg_clamped;

  // Clamp a written window size into the legal range
  always_comb begin
    if (cfg_wdata < WIN_MIN) begin
      cfg_clamped = WIN_MIN;
    end else if (cfg_wdata > WIN_MAX) begin
      cfg_clamped = WIN_MAX;
    end else begin
      cfg_clamped = cfg_wdata;
    end
  end

  // Handshake: advance the input register unless a result would be blocked
  assign full         = (fill_count >= window_size);
  assign gives_result = full || ((fill_count + WIN_W'(1)) == window_size);
  assign s1_adv       = s1_valid && (!res_valid || medians.ready || !gives_result);
  assign samples.ready = !s1_valid || s1_adv;
  assign medians.valid = res_valid;
  assign medians.median_doubled = res_median;

  // Pick the history slot and step the oldest pointer
  always_comb begin
    hist_idx = full ? oldest_pointer : fill_count[PTR_W-1:0];
    old_sample = history[oldest_pointer];
    ptr_inc = WIN_W'(oldest_pointer) + WIN_W'(1);
    oldest_pointer_next = (ptr_inc >= window_size) ? '0 : ptr_inc[PTR_W-1:0];
    ins_count = full ? (window_size - WIN_W'(1)) : fill_count;
  end

  // Once the window is full, drop one copy of the oldest sample; then insert the new one
  always_comb begin
    logic lt;
    for (int i = 0; i < MAX_WINDOW; i++) begin
      lt = sorted_window[i] < old_sample;
      if (!full || lt || (i == MAX_WINDOW - 1)) begin
        removed[i] = sorted_window[i];
      end else begin
        removed[i] = sorted_window[(i + 1) % MAX_WINDOW];
      end
    end
    for (int i = 0; i < MAX_WINDOW; i++) begin
      below[i] = (WIN_W'(i) < ins_count) && (removed[i] <= s1_sample);
    end
    for (int i = 0; i < MAX_WINDOW; i++) begin
      if (below[i]) begin
        sorted_next[i] = removed[i];
      end else if ((i == 0) || below[(i + MAX_WINDOW - 1) % MAX_WINDOW]) begin
        sorted_next[i] = s1_sample;
      end else begin
        sorted_next[i] = removed[(i + MAX_WINDOW - 1) % MAX_WINDOW];
      end
    end
  end

  // Median of the updated window, doubled
  always_comb begin
    med_hi = window_size >> 1;
    idx_hi = med_hi[PTR_W-1:0];
    idx_lo = window_size[0] ? idx_hi : (idx_hi - PTR_W'(1));
    median_next = MEDIAN_W'(sorted_next[idx_lo]) + MEDIAN_W'(sorted_next[idx_hi]);
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (samples.valid && samples.ready) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
    if (samples.valid && samples.ready) begin
      s1_sample <= samples.sample;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_adv && gives_result) begin
      res_valid <= 1'b1;
    end else if (medians.ready) begin
      res_valid <= 1'b0;
    end
    if (s1_adv && gives_result) begin
      res_median <= median_next;
    end
  end

  // Window control: config restarts the window, each item advances it
  always_ff @(posedge clk) begin
    if (rst) begin
      window_size    <= WIN_RESET;
      fill_count     <= '0;
      oldest_pointer <= '0;
    end else if (cfg_we) begin
      window_size    <= cfg_clamped;
      fill_count     <= '0;
      oldest_pointer <= '0;
    end else if (s1_adv) begin
      if (full) begin
        oldest_pointer <= oldest_pointer_next;
      end else begin
        fill_count <= fill_count + WIN_W'(1);
      end
    end
  end

  // History slots and sorted cells
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      history[hist_idx] <= s1_sample;
      for (int i = 0; i < MAX_WINDOW; i++) begin
        sorted_window[i] <= sorted_next[i];
      end
    end
  end

  // Checks on the window bookkeeping
  `SWM_ASSERT_SAME(a_fill_bound, 1'b1, fill_count <= window_size)
  `SWM_ASSERT_SAME(a_ptr_only_full, oldest_pointer != '0, fill_count == window_size)
  `SWM_ASSERT_NEXT(a_cfg_restart, cfg_we, (fill_count == '0) && (oldest_pointer == '0))
  `SWM_ASSERT_SAME(a_win_range, 1'b1, (window_size >= WIN_MIN) && (window_size <= WIN_MAX))

endmodule
